/* rtl/avs_pkg.sv */
package avs_pkg;

    localparam int AVS_SAMPLE_WIDTH = 32;
    localparam int IO_WIDTH         = 32;
    localparam int VOL_WIDTH        = 7;
    localparam int BYTES_WIDTH      = 3;
    localparam int CFG_DATA_WIDTH   = 7;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int GAIN_WIDTH       = 33;
    localparam int GAIN_FRAC        = 32;
    localparam int VOL_MAX          = 100;
    localparam longint unsigned GainDen = 64'd10000;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VOLUME = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MUTED  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BYTES  = 2'd2;

    localparam logic [VOL_WIDTH-1:0]   VOL_RESET   = 7'd100;
    localparam logic [BYTES_WIDTH-1:0] BYTES_RESET = 3'd2;
    localparam logic [GAIN_WIDTH-1:0]  GAIN_UNITY  = 33'h1_0000_0000;

    typedef logic [GAIN_WIDTH-1:0] gain_tab_t [0:VOL_MAX];

    typedef struct packed {
        logic [GAIN_WIDTH-1:0]  gain;
        logic [BYTES_WIDTH-1:0] sample_bytes;
    } avs_cfg_t;

    typedef struct packed {
        logic [IO_WIDTH-1:0] sample_in;
    } avs_in_beat_t;

    typedef struct packed {
        logic [IO_WIDTH-1:0] sample_out;
    } avs_out_beat_t;

    // Quadratic taper: floor(v*v*2^32/10000), built at elaboration only
    function automatic gain_tab_t build_gain_table();
        gain_tab_t tab;
        longint unsigned num;
        for (int v = 0; v <= VOL_MAX; v++)
        begin
            num    = (longint'(v) * longint'(v)) << GAIN_FRAC;
            tab[v] = GAIN_WIDTH'(num / GainDen);
        end
        return tab;
    endfunction

    localparam gain_tab_t GAIN_TABLE = build_gain_table();

endpackage

/* rtl/avs_stream_if.sv */
interface avs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/avs_config.sv */
module avs_config
    import avs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output avs_cfg_t                   cfg
);

    logic [VOL_WIDTH-1:0]   vol_reg,   vol_next;
    logic                   muted_reg, muted_next;
    logic [BYTES_WIDTH-1:0] bytes_reg, bytes_next;
    logic [GAIN_WIDTH-1:0]  gain_reg,  gain_next;
    logic [VOL_WIDTH-1:0]   wr_vol;

    assign wr_vol = cfg_wdata[VOL_WIDTH-1:0];

    always_comb
    begin
        vol_next   = vol_reg;
        muted_next = muted_reg;
        bytes_next = bytes_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_VOLUME: vol_next   = (wr_vol > VOL_RESET) ? VOL_RESET : wr_vol;
                REG_MUTED:  muted_next = cfg_wdata[0];
                REG_BYTES:  bytes_next = cfg_wdata[BYTES_WIDTH-1:0];
                default:    ;
            endcase
        end
        // rebuild gain from the values that take effect at this edge
        gain_next = muted_next ? '0 : GAIN_TABLE[vol_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg   <= VOL_RESET;
            muted_reg <= 1'b0;
            bytes_reg <= BYTES_RESET;
            gain_reg  <= GAIN_UNITY;
        end
        else
        begin
            vol_reg   <= vol_next;
            muted_reg <= muted_next;
            bytes_reg <= bytes_next;
            gain_reg  <= gain_next;
        end
    end

    assign cfg.gain         = gain_reg;
    assign cfg.sample_bytes = bytes_reg;

endmodule

/* rtl/avs_datapath.sv */
module avs_datapath
    import avs_pkg::*;
#(
    parameter int SAMPLE_WIDTH = AVS_SAMPLE_WIDTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  avs_cfg_t cfg,
    avs_stream_if.sink   in_stream,
    avs_stream_if.source out_stream
);

    localparam int PW = SAMPLE_WIDTH + GAIN_WIDTH + 1;
    localparam logic [PW-1:0] HALF_LSB = PW'(1) << (GAIN_FRAC - 1);

    // stage 1: sign-extended sample
    logic                    s1_valid_reg;
    logic [SAMPLE_WIDTH-1:0] s1_x_reg,    s1_x_next;
    logic [SAMPLE_WIDTH-1:0] s1_mask_reg, s1_mask_next;
    logic                    s1_bypass_reg, s1_bypass_next;
    // stage 2: output register
    logic                    s2_valid_reg;
    logic [IO_WIDTH-1:0]     s2_data_reg, s2_data_next;

    logic                    s1_load, s2_load;
    logic [SAMPLE_WIDTH-1:0] raw, lane_mask, sign_mask;
    logic [5:0]              lane_w;
    logic                    sign;

    logic signed [SAMPLE_WIDTH-1:0] xs;
    logic signed [GAIN_WIDTH:0]     gs;
    logic signed [PW-1:0]           prod;
    logic [PW-1:0]                  rounded;
    logic [SAMPLE_WIDTH-1:0]        scaled;

    assign s2_load         = s1_valid_reg && (!s2_valid_reg || out_stream.ready);
    assign in_stream.ready = !s1_valid_reg || s2_load;
    assign s1_load         = in_stream.valid && in_stream.ready;

    assign raw = in_stream.data.sample_in[SAMPLE_WIDTH-1:0];

    always_comb
    begin
        case (cfg.sample_bytes)
            3'd1:    lane_w = 6'd8;
            3'd2:    lane_w = 6'd16;
            3'd3:    lane_w = 6'd24;
            3'd4:    lane_w = 6'd32;
            default: lane_w = 6'(SAMPLE_WIDTH);
        endcase
        if (lane_w > 6'(SAMPLE_WIDTH))
            lane_w = 6'(SAMPLE_WIDTH);
        s1_bypass_next = (cfg.sample_bytes == 3'd0) || (cfg.sample_bytes > 3'd4);
        lane_mask = {SAMPLE_WIDTH{1'b1}} >> (6'(SAMPLE_WIDTH) - lane_w);
        sign_mask = lane_mask ^ (lane_mask >> 1);
        sign      = |(raw & sign_mask);
        if (s1_bypass_next)
        begin
            s1_x_next    = raw;
            s1_mask_next = {SAMPLE_WIDTH{1'b1}};
        end
        else
        begin
            s1_x_next    = (raw & lane_mask) | (sign ? ~lane_mask : '0);
            s1_mask_next = lane_mask;
        end
    end

    always_comb
    begin
        xs      = signed'(s1_x_reg);
        gs      = signed'({1'b0, cfg.gain});
        prod    = xs * gs;
        rounded = unsigned'(prod) + HALF_LSB;
        scaled  = rounded[GAIN_FRAC +: SAMPLE_WIDTH];
        if (s1_bypass_reg)
            s2_data_next = IO_WIDTH'(s1_x_reg);
        else
            s2_data_next = IO_WIDTH'(scaled & s1_mask_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_stream.ready)
                s1_valid_reg <= in_stream.valid;
            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (out_stream.ready)
                s2_valid_reg <= 1'b0;
        end
    end

    // payload: hold unless a beat moves in
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_x_reg      <= s1_x_next;
            s1_mask_reg   <= s1_mask_next;
            s1_bypass_reg <= s1_bypass_next;
        end
        if (s2_load)
            s2_data_reg <= s2_data_next;
    end

    assign out_stream.valid           = s2_valid_reg;
    assign out_stream.data.sample_out = s2_data_reg;

endmodule

/* rtl/audio_volume_scaler_unit.sv */
// An accepted input beat passes through the sign-extension register and then the
// output register. Throughput: one sample per cycle while out_stream.ready holds;
// the single 32x33 gain multiply sits between those two registers.
// Reset (rst_n, async, active low): volume 100, unmuted, 2-byte samples,
// gain 2^32 (unity); both pipeline stages empty.
module audio_volume_scaler_unit
    import avs_pkg::*;
#(
    parameter int SAMPLE_WIDTH = AVS_SAMPLE_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    avs_stream_if.sink                 in_stream,
    avs_stream_if.source               out_stream
);

    avs_cfg_t cfg;

    avs_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    avs_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_stream  (in_stream),
        .out_stream (out_stream)
    );

endmodule

/* tb/tb.sv */
module tb;
    import avs_pkg::*;

    localparam int                         SAMPLE_W   = AVS_SAMPLE_WIDTH;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int                         RAND_PHASES = 16;
    localparam int                         PHASE_ITEMS = 27;

    typedef struct {
        avs_in_beat_t beat;
        bit           hold;
    } pend_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;

    avs_stream_if #(.T(avs_in_beat_t))  in_if ();
    avs_stream_if #(.T(avs_out_beat_t)) out_if ();

    audio_volume_scaler_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    // mirror of the block's configuration and gain
    logic [VOL_WIDTH-1:0]   vol_cfg;
    logic                   mute_cfg;
    logic [BYTES_WIDTH-1:0] bytes_cfg;
    logic [GAIN_WIDTH-1:0]  gain_q32;

    pend_beat_t          sample_q [$];
    logic [IO_WIDTH-1:0] scaled_q [$];
    pend_beat_t          next_beat;
    logic [IO_WIDTH-1:0] want_sample;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_settings = 0;

    always #10 clk = ~clk;

    function automatic logic [GAIN_WIDTH-1:0] taper_gain(logic [VOL_WIDTH-1:0] vol, logic mute);
        logic [63:0] num;
        if (mute || vol == 0)
            return '0;
        if (vol >= VOL_MAX)
            return GAIN_UNITY;
        num = (64'(vol) * 64'(vol)) << GAIN_FRAC;
        return GAIN_WIDTH'(num / GainDen);
    endfunction

    function automatic logic [IO_WIDTH-1:0] scaled_sample(logic [IO_WIDTH-1:0] raw);
        int unsigned w;
        logic [63:0] keep;
        logic [63:0] x;
        logic [63:0] prod;
        logic [63:0] shifted;
        // bad width codes pass the sample through untouched
        if (bytes_cfg < 1 || bytes_cfg > 4)
            return raw;
        w = bytes_cfg * 8;
        if (w > SAMPLE_W)
            w = SAMPLE_W;
        keep = (64'd1 << w) - 64'd1;
        x = {32'd0, raw} & keep;
        if (x[w-1])
            x = x | ~keep;
        prod = x * {31'd0, gain_q32} + 64'h8000_0000;
        shifted = {{32{prod[63]}}, prod[63:32]};
        return IO_WIDTH'(shifted & keep);
    endfunction

    // bias toward full-scale, zero and -1 for the current width, junk above it
    function automatic logic [IO_WIDTH-1:0] pick_sample();
        int unsigned w;
        logic [IO_WIDTH-1:0] corner;
        logic [IO_WIDTH-1:0] keep;
        w = (bytes_cfg >= 1 && bytes_cfg <= 4) ? bytes_cfg * 8 : 32;
        if ($urandom_range(3) != 0)
            return $urandom;
        case ($urandom_range(4))
            0:       corner = (32'd1 << (w - 1)) - 32'd1;
            1:       corner = 32'd1 << (w - 1);
            2:       corner = '1;
            3:       corner = '0;
            default: corner = 32'd1;
        endcase
        if (w < 32)
        begin
            keep   = (32'd1 << w) - 32'd1;
            corner = (corner & keep) | ($urandom & ~keep);
        end
        return corner;
    endfunction

    task automatic report_mismatch(string what, logic [IO_WIDTH-1:0] got,
                                   logic [IO_WIDTH-1:0] want);
        $display("mismatch at %0t: %s: got %08h want %08h (vol %0d mute %0b bytes %0d)",
                 $realtime, what, got, want, vol_cfg, mute_cfg, bytes_cfg);
        n_errors++;
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_VOLUME: vol_cfg   = (val > VOL_MAX) ? VOL_WIDTH'(VOL_MAX) : val;
            REG_MUTED:  mute_cfg  = val[0];
            REG_BYTES:  bytes_cfg = val[BYTES_WIDTH-1:0];
            default:    ;
        endcase
        gain_q32 = taper_gain(vol_cfg, mute_cfg);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_DATA_WIDTH-1:0] vol_raw,
                              logic [CFG_DATA_WIDTH-1:0] mute_raw,
                              logic [CFG_DATA_WIDTH-1:0] bytes_raw);
        write_reg(REG_VOLUME, vol_raw);
        write_reg(REG_MUTED, mute_raw);
        write_reg(REG_BYTES, bytes_raw);
        n_settings++;
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 87; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    task automatic send(logic [IO_WIDTH-1:0] s, bit hold);
        pend_beat_t p;
        p.beat.sample_in = s;
        p.hold           = hold;
        sample_q.push_back(p);
    endtask

    // drain everything, then let the pipeline settle before touching registers
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || in_if.valid || scaled_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                scaled_q.push_back(scaled_sample(in_if.data.sample_in));
                n_accepted++;
            end
            if (!in_if.valid || in_if.ready)
            begin
                // hold a marked beat until every earlier result is back
                if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct
                    && !(sample_q[0].hold && scaled_q.size() != 0))
                begin
                    next_beat = sample_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.data  <= next_beat.beat;
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                n_results++;
                if (scaled_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected",
                                    out_if.data.sample_out, '0);
                end
                else
                begin
                    want_sample = scaled_q.pop_front();
                    if (out_if.data.sample_out !== want_sample)
                        report_mismatch("sample_out", out_if.data.sample_out, want_sample);
                end
            end
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d samples sent, %0d results seen", n_accepted, n_results);
        $display("** audio_volume_scaler_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int n;
        logic [CFG_DATA_WIDTH-1:0] vol_raw;
        logic [CFG_DATA_WIDTH-1:0] mute_raw;
        logic [CFG_DATA_WIDTH-1:0] bytes_raw;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        vol_cfg      = VOL_RESET;
        mute_cfg     = 1'b0;
        bytes_cfg    = BYTES_RESET;
        gain_q32     = GAIN_UNITY;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults: unity gain, 16-bit samples
        send(32'h0000_7FFF, 1'b0);
        send(32'hABCD_8000, 1'b0);
        wait_idle();

        set_idling(1);
        set_config(7'd100, 7'd0, 7'd1);
        send(32'h0000_007F, 1'b0);
        send(32'h0000_0080, 1'b0);
        send(32'hFFFF_FFFF, 1'b0);
        wait_idle();

        set_idling(2);
        set_config(7'd50, 7'd0, 7'd3);
        send(32'h007F_FFFF, 1'b0);
        send(32'h0080_0000, 1'b0);
        send(32'hFF00_0001, 1'b0);
        wait_idle();

        set_idling(3);
        set_config(7'd99, 7'd0, 7'd4);
        send(32'h7FFF_FFFF, 1'b0);
        send(32'h8000_0000, 1'b0);
        send(32'hFFFF_FFFF, 1'b0);
        wait_idle();

        // volume above range saturates to full scale
        set_idling(0);
        set_config(7'd127, 7'd0, 7'd4);
        send(32'h8000_0000, 1'b0);
        send(32'h1234_5678, 1'b0);
        wait_idle();

        // upper data bits of the mute write are dropped
        write_reg(REG_MUTED, 7'h03);
        send(32'h7FFF_FFFF, 1'b0);
        wait_idle();

        set_config(7'd0, 7'h02, 7'd4);
        send(32'h8000_0000, 1'b0);
        wait_idle();

        set_idling(1);
        set_config(7'd1, 7'd0, 7'd2);
        send(32'h0000_7FFF, 1'b0);
        send(32'h0000_8000, 1'b0);
        wait_idle();

        // bad width codes, including one hidden under upper data bits
        set_config(7'd100, 7'd0, 7'd0);
        send(32'hDEAD_BEEF, 1'b0);
        wait_idle();
        write_reg(REG_BYTES, 7'h0F);
        send(32'h8000_0001, 1'b0);
        wait_idle();
        write_reg(REG_BYTES, 7'd5);
        send(32'hFFFF_FFFF, 1'b0);
        wait_idle();
        write_reg(REG_BYTES, 7'd6);
        write_reg(REG_UNUSED, 7'h7F);
        send(32'h0000_0001, 1'b0);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_idling(p);
            case (p)
                0:       vol_raw = 7'd0;
                1:       vol_raw = 7'd100;
                2:       vol_raw = 7'($urandom_range(101, 127));
                3:       vol_raw = 7'd1;
                4:       vol_raw = 7'd99;
                default: vol_raw = 7'($urandom_range(127));
            endcase
            mute_raw = 7'($urandom_range(127));
            mute_raw[0] = (p % 5 == 2);
            bytes_raw = 7'($urandom_range(127));
            if (p < 4)
                bytes_raw[2:0] = 3'(p + 1);
            else if ($urandom_range(5) != 0)
                bytes_raw[2:0] = 3'($urandom_range(1, 4));
            set_config(vol_raw, mute_raw, bytes_raw);
            write_reg(REG_UNUSED, 7'($urandom_range(127)));

            n = PHASE_ITEMS;
            for (int i = 0; i < n; i++)
                send(pick_sample(), (p % 2 == 1) && (i == n / 2));
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("covered %0d samples under %0d volume/mute/width settings, %0d results checked",
                 n_accepted, n_settings, n_results);
        $display("settings spanned silence, unity, saturated volume, mute, all widths and bad widths");
        if (n_errors == 0)
            $display("** audio_volume_scaler_unit: PASSED **");
        else
            $display("** audio_volume_scaler_unit: FAILED **");
        $finish;
    end

endmodule
